FILE: hdl/bdeq_pkg.sv
`default_nettype none

package bdeq_pkg;

    localparam int MAX_DEPTH_DEFAULT = 16;
    localparam int DATA_W            = 32;
    localparam int CAP_W             = 5;
    localparam int OCC_W             = 5;
    localparam int FUNC_W            = 2;

    // ok, front_value, rear_value, is_empty, is_full, occupancy
    localparam int RESULT_W = 1 + DATA_W + DATA_W + 1 + 1 + OCC_W;

    localparam logic [CAP_W-1:0]  CAP_RESET   = CAP_W'(16);
    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_REAR  = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_POP_REAR   = 2'd3
    } func_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

`default_nettype wire

FILE: hdl/bounded_double_ended_queue.sv
`default_nettype none

// Channel    | Dir | Signals                                | Payload
// -----------+-----+----------------------------------------+------------------------------------
// config     | in  | cfg_wr_en, cfg_wr_data[4:0]            | capacity
// request    | in  | s_tvalid, s_tready, s_tuser, s_tdata   | func (tuser), data_value (tdata)
// result     | out | m_tvalid, m_tready, m_tdata            | ok, front, rear, empty, full, occ
//
// A push, a failed item or a pop that empties the queue gives its result from ST_IDLE; a pop
// that leaves entries first waits in ST_READ for the registered ring memory read of the new end.
// Reset clears the pointers, the occupancy and the result valid, and loads capacity 16;
// the ring memory is not cleared, as only written entries are ever read.
// A request is taken while a result waits only if that result leaves in the same
// cycle; a stalled result holds the request side.

module bounded_double_ended_queue #(
    parameter int MAX_DEPTH = bdeq_pkg::MAX_DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bdeq_pkg::CAP_W-1:0]    cfg_wr_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,   // [31:0] data_value
    input  wire logic [1:0]                    s_tuser,   // [1:0] func
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [0] ok, [32:1] front_value, [64:33] rear_value, [65] is_empty,
    // [66] is_full, [71:67] occupancy
    output logic [bdeq_pkg::RESULT_W-1:0]      m_tdata
);

    localparam int PTR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int CMP_W = (CNT_W > bdeq_pkg::CAP_W) ? CNT_W : bdeq_pkg::CAP_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_DEPTH);

    // Ring memory: one write port, one registered read port
    logic [bdeq_pkg::DATA_W-1:0] ring_mem [MAX_DEPTH];
    logic [bdeq_pkg::DATA_W-1:0] rd_data_reg;

    bdeq_pkg::state_t state_reg, state_next;

    logic [PTR_W-1:0]           head_reg, head_next;
    logic [PTR_W-1:0]           tail_reg, tail_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [bdeq_pkg::CAP_W-1:0] capacity_reg;
    logic                       ok_reg, ok_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       rd_front_reg, rd_front_next;

    // Cached end values so that pushes need no memory read
    logic [bdeq_pkg::DATA_W-1:0] front_reg, front_next;
    logic [bdeq_pkg::DATA_W-1:0] rear_reg, rear_next;

    logic                    accept;
    logic                    need_read;
    logic                    mem_we;
    logic [PTR_W-1:0]        wr_addr;
    logic [PTR_W-1:0]        rd_addr;
    logic                    is_empty;
    logic                    is_full;
    logic [PTR_W-1:0]        head_inc, head_dec, tail_inc, tail_dec;
    bdeq_pkg::func_t         func;

    assign func   = bdeq_pkg::func_t'(s_tuser);
    assign accept = s_tvalid && s_tready;

    // Full when at the configured capacity or at the memory depth
    assign is_empty = (count_reg == '0);
    assign is_full  = (CMP_W'(count_reg) >= CMP_W'(capacity_reg)) || (count_reg == CNT_MAX);

    assign head_inc = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
    assign head_dec = (head_reg == '0) ? PTR_LAST : head_reg - PTR_W'(1);
    assign tail_inc = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);
    assign tail_dec = (tail_reg == '0) ? PTR_LAST : tail_reg - PTR_W'(1);

    // Operation decode: pointer, count and cache updates for the accepted item
    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        front_next    = front_reg;
        rear_next     = rear_reg;
        ok_next       = ok_reg;
        rd_front_next = rd_front_reg;
        need_read     = 1'b0;
        mem_we        = 1'b0;
        wr_addr       = head_reg;
        rd_addr       = head_inc;
        if (accept)
        begin
            ok_next = 1'b0;
            unique case (func)
                bdeq_pkg::FUNC_PUSH_FRONT:
                begin
                    if (!is_full)
                    begin
                        ok_next    = 1'b1;
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        front_next = s_tdata;
                        if (is_empty)
                        begin
                            tail_next = head_reg;
                            rear_next = s_tdata;
                        end
                        else
                        begin
                            head_next = head_dec;
                            wr_addr   = head_dec;
                        end
                    end
                end
                bdeq_pkg::FUNC_PUSH_REAR:
                begin
                    if (!is_full)
                    begin
                        ok_next    = 1'b1;
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        rear_next  = s_tdata;
                        if (is_empty)
                        begin
                            tail_next  = head_reg;
                            front_next = s_tdata;
                        end
                        else
                        begin
                            tail_next = tail_inc;
                            wr_addr   = tail_inc;
                        end
                    end
                end
                bdeq_pkg::FUNC_POP_FRONT:
                begin
                    if (!is_empty)
                    begin
                        ok_next    = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                        // Pointers hold when the last entry leaves
                        if (count_reg != CNT_W'(1))
                        begin
                            head_next     = head_inc;
                            rd_addr       = head_inc;
                            need_read     = 1'b1;
                            rd_front_next = 1'b1;
                        end
                    end
                end
                bdeq_pkg::FUNC_POP_REAR:
                begin
                    if (!is_empty)
                    begin
                        ok_next    = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                        if (count_reg != CNT_W'(1))
                        begin
                            tail_next     = tail_dec;
                            rd_addr       = tail_dec;
                            need_read     = 1'b1;
                            rd_front_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
        else if (state_reg == bdeq_pkg::ST_READ)
        begin
            // Refill the end cache from the fetched entry
            if (rd_front_reg)
                front_next = rd_data_reg;
            else
                rear_next = rd_data_reg;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdeq_pkg::ST_IDLE:
            begin
                if (accept && need_read)
                    state_next = bdeq_pkg::ST_READ;
            end
            bdeq_pkg::ST_READ:
            begin
                state_next = bdeq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bdeq_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        s_tready     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            bdeq_pkg::ST_IDLE:
            begin
                s_tready = !m_valid_reg || m_tready;
                if (accept && !need_read)
                    m_valid_next = 1'b1;
            end
            bdeq_pkg::ST_READ:
            begin
                m_valid_next = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bdeq_pkg::ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            capacity_reg <= bdeq_pkg::CAP_RESET;
            ok_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
            rd_front_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            ok_reg       <= ok_next;
            m_valid_reg  <= m_valid_next;
            rd_front_reg <= rd_front_next;
            if (cfg_wr_en)
                capacity_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        rear_reg  <= rear_next;
    end

    // The read port reads every cycle and may hit the entry being written; its data is used
    // only after a pop, which writes nothing.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[wr_addr] <= s_tdata;
        rd_data_reg <= ring_mem[rd_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {
        bdeq_pkg::OCC_W'(count_reg),
        is_full,
        is_empty,
        is_empty ? bdeq_pkg::EMPTY_VALUE : rear_reg,
        is_empty ? bdeq_pkg::EMPTY_VALUE : front_reg,
        ok_reg
    };

endmodule

`default_nettype wire
